// ===== hdl/mlr_pkg.sv =====
// ----------------------------------------------------------------------------
// mlr_pkg
// Shared codes for the midpoint line rasterizer: the item kind selector.
// ----------------------------------------------------------------------------
package mlr_pkg;

  // kind of an input beat, carried on tuser
  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_STEP = 1'b1
  } kind_t;

endpackage

// ===== hdl/midpoint_line_rasterizer.sv =====
// ----------------------------------------------------------------------------
// midpoint_line_rasterizer
// Midpoint line rasterizer for all octants with stream in and out ports.
// ----------------------------------------------------------------------------
// Usage: a load beat (tuser 0) takes two endpoints and starts a new line; it
// gives no output beat. Each step beat (tuser 1) gives one output beat: the
// next pixel of the line, with tlast on the final one, or tuser 0 and zero
// data once no line is active. Pixels run along the major axis from the
// endpoint that sorts first after the mirror up to but not including the
// other. One beat of either kind is taken every cycle: the line state
// (position and decision term) is updated per step by parallel adds and
// compares, and a load is prepared in the same cycle. A new beat enters as
// a waiting result leaves, so the input stalls only while the output stalls.
// ----------------------------------------------------------------------------
module midpoint_line_rasterizer
  import mlr_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // start_x, start_y, end_x, end_y
  input  logic [((4*COORD_BITS+7)/8)*8-1:0]      s_tdata,
  // kind
  input  logic                                   s_tuser,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // pixel_x, pixel_y
  output logic [((2*COORD_BITS+7)/8)*8-1:0]      m_tdata,
  // pixel_valid
  output logic                                   m_tuser,
  output logic                                   m_tlast
);

  localparam int CB     = COORD_BITS;
  localparam int OUT_W  = ((2*COORD_BITS+7)/8)*8;
  localparam int PKT_W  = 2*COORD_BITS + 2;

  kind_t           kind;
  logic            accept, push, out_ready_int;
  logic            pixel_valid, last_pixel;
  logic [CB-1:0]   pixel_x, pixel_y;
  logic [PKT_W-1:0] pkt, pkt_out;

  assign kind     = kind_t'(s_tuser);
  assign s_tready = out_ready_int;
  assign accept   = s_tvalid && s_tready;
  assign push     = accept && (kind == KIND_STEP);

  mlr_stepper #(
    .COORD_BITS(COORD_BITS)
  ) u_stepper (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .kind       (kind),
    .start_x    (s_tdata[CB-1:0]),
    .start_y    (s_tdata[2*CB-1:CB]),
    .end_x      (s_tdata[3*CB-1:2*CB]),
    .end_y      (s_tdata[4*CB-1:3*CB]),
    .pixel_valid(pixel_valid),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .last_pixel (last_pixel)
  );

  // result beat: last, valid, y, x
  assign pkt = {last_pixel, pixel_valid, pixel_y, pixel_x};

  mlr_out_reg #(
    .DATA_BITS(PKT_W)
  ) u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(pkt),
    .ready    (out_ready_int),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_data (pkt_out)
  );

  assign m_tdata = OUT_W'(pkt_out[2*CB-1:0]);
  assign m_tuser = pkt_out[2*CB];
  assign m_tlast = pkt_out[2*CB+1];

endmodule

// ===== hdl/mlr_setup.sv =====
// ----------------------------------------------------------------------------
// mlr_setup
// Line preparation: mirror, axis swap and endpoint ordering, giving the
// start position, deltas and initial decision term of a new line.
// ----------------------------------------------------------------------------
module mlr_setup #(
  parameter int COORD_BITS = 12
) (
  input  logic [COORD_BITS-1:0] start_x,
  input  logic [COORD_BITS-1:0] start_y,
  input  logic [COORD_BITS-1:0] end_x,
  input  logic [COORD_BITS-1:0] end_y,
  output logic                  mirror,
  output logic                  swap,
  output logic                  active,
  output logic [COORD_BITS-1:0] major_pos,
  output logic [COORD_BITS-1:0] minor_pos,
  output logic [COORD_BITS-1:0] major_end,
  output logic [COORD_BITS:0]   major_delta,
  output logic [COORD_BITS:0]   minor_delta,
  output logic [COORD_BITS+3:0] decision
);

  localparam int W = COORD_BITS + 2;
  localparam int D = COORD_BITS + 4;

  logic signed [W-1:0] ax, ay, bx, by;
  logic signed [W-1:0] dx, dy, adx, ady;
  logic signed [W-1:0] axm, bxm, dmaj;
  logic signed [W-1:0] pa_x, pa_y, pb_x;
  logic signed [W-1:0] sa, ma, sb;
  logic        [W-1:0] maj_abs, min_abs;
  logic        [D-1:0] maj_ext, min_ext;
  logic                order;

  // sign extend the endpoints
  assign ax = $signed({{2{start_x[COORD_BITS-1]}}, start_x});
  assign ay = $signed({{2{start_y[COORD_BITS-1]}}, start_y});
  assign bx = $signed({{2{end_x[COORD_BITS-1]}}, end_x});
  assign by = $signed({{2{end_y[COORD_BITS-1]}}, end_y});

  // raw extents and their magnitudes
  assign dx  = bx - ax;
  assign dy  = by - ay;
  assign adx = dx[W-1] ? -dx : dx;
  assign ady = dy[W-1] ? -dy : dy;

  // negative slope mirrors x, steep slope swaps the axes
  assign mirror = (dx[W-1] && !dy[W-1] && (dy != '0)) ||
                  (!dx[W-1] && (dx != '0) && dy[W-1]);
  assign swap   = ady > adx;

  assign axm = mirror ? -ax : ax;
  assign bxm = mirror ? -bx : bx;

  // order endpoints by ascending major coordinate
  assign dmaj  = swap ? dy : (mirror ? -dx : dx);
  assign order = dmaj[W-1];

  assign pa_x = order ? bxm : axm;
  assign pa_y = order ? by  : ay;
  assign pb_x = order ? axm : bxm;

  assign sa = swap ? pa_y : pa_x;
  assign ma = swap ? pa_x : pa_y;
  assign sb = swap ? (order ? ay : by) : pb_x;

  // positions wrap to the coordinate width
  assign major_pos = sa[COORD_BITS-1:0];
  assign minor_pos = ma[COORD_BITS-1:0];
  assign major_end = sb[COORD_BITS-1:0];

  // after the transforms both deltas are the extent magnitudes
  assign maj_abs     = swap ? ady : adx;
  assign min_abs     = swap ? adx : ady;
  assign major_delta = maj_abs[COORD_BITS:0];
  assign minor_delta = min_abs[COORD_BITS:0];

  // initial decision 2*minor - major
  assign maj_ext  = {{(D-COORD_BITS-1){1'b0}}, major_delta};
  assign min_ext  = {{(D-COORD_BITS-1){1'b0}}, minor_delta};
  assign decision = {min_ext[D-2:0], 1'b0} - maj_ext;

  assign active = major_delta != '0;

endmodule

// ===== hdl/mlr_stepper.sv =====
// ----------------------------------------------------------------------------
// mlr_stepper
// Running line state: loads a prepared line and advances one pixel per
// step beat, giving the pixel in the original orientation.
// ----------------------------------------------------------------------------
module mlr_stepper
  import mlr_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  kind_t                 kind,
  input  logic [COORD_BITS-1:0] start_x,
  input  logic [COORD_BITS-1:0] start_y,
  input  logic [COORD_BITS-1:0] end_x,
  input  logic [COORD_BITS-1:0] end_y,
  output logic                  pixel_valid,
  output logic [COORD_BITS-1:0] pixel_x,
  output logic [COORD_BITS-1:0] pixel_y,
  output logic                  last_pixel
);

  localparam int D = COORD_BITS + 4;

  logic                  line_active, mirror_flag, swap_flag;
  logic [COORD_BITS-1:0] major_pos, minor_pos, major_end;
  logic [COORD_BITS:0]   major_delta, minor_delta;
  logic [D-1:0]          decision_term;

  logic                  ld_mirror, ld_swap, ld_active;
  logic [COORD_BITS-1:0] ld_major_pos, ld_minor_pos, ld_major_end;
  logic [COORD_BITS:0]   ld_major_delta, ld_minor_delta;
  logic [D-1:0]          ld_decision;

  logic [COORD_BITS-1:0] px_sel, py_sel, major_next;
  logic [D-1:0]          maj_ext, min_ext, diff, inc_up, inc_flat;
  logic                  last, go_up;

  mlr_setup #(
    .COORD_BITS(COORD_BITS)
  ) u_setup (
    .start_x    (start_x),
    .start_y    (start_y),
    .end_x      (end_x),
    .end_y      (end_y),
    .mirror     (ld_mirror),
    .swap       (ld_swap),
    .active     (ld_active),
    .major_pos  (ld_major_pos),
    .minor_pos  (ld_minor_pos),
    .major_end  (ld_major_end),
    .major_delta(ld_major_delta),
    .minor_delta(ld_minor_delta),
    .decision   (ld_decision)
  );

  // pixel from the current position, transforms undone
  assign px_sel      = swap_flag ? minor_pos : major_pos;
  assign py_sel      = swap_flag ? major_pos : minor_pos;
  assign major_next  = major_pos + 1'b1;
  assign last        = major_next == major_end;

  assign pixel_valid = line_active;
  assign pixel_x     = !line_active ? '0 : (mirror_flag ? (~px_sel + 1'b1) : px_sel);
  assign pixel_y     = line_active ? py_sel : '0;
  assign last_pixel  = line_active && last;

  // decision increments
  assign maj_ext  = {{(D-COORD_BITS-1){1'b0}}, major_delta};
  assign min_ext  = {{(D-COORD_BITS-1){1'b0}}, minor_delta};
  assign diff     = min_ext - maj_ext;
  assign inc_up   = {diff[D-2:0], 1'b0};
  assign inc_flat = {min_ext[D-2:0], 1'b0};
  assign go_up    = !decision_term[D-1] && (decision_term != '0);

  // line state
  always_ff @(posedge clk) begin
    if (rst) begin
      line_active   <= 1'b0;
      mirror_flag   <= 1'b0;
      swap_flag     <= 1'b0;
      major_pos     <= '0;
      minor_pos     <= '0;
      major_end     <= '0;
      major_delta   <= '0;
      minor_delta   <= '0;
      decision_term <= '0;
    end else if (accept) begin
      unique case (kind)
        KIND_LOAD: begin
          line_active   <= ld_active;
          mirror_flag   <= ld_mirror;
          swap_flag     <= ld_swap;
          major_pos     <= ld_major_pos;
          minor_pos     <= ld_minor_pos;
          major_end     <= ld_major_end;
          major_delta   <= ld_major_delta;
          minor_delta   <= ld_minor_delta;
          decision_term <= ld_decision;
        end
        KIND_STEP: begin
          if (line_active) begin
            major_pos <= major_next;
            if (go_up) begin
              minor_pos     <= minor_pos + 1'b1;
              decision_term <= decision_term + inc_up;
            end else begin
              decision_term <= decision_term + inc_flat;
            end
            if (last) begin
              line_active <= 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== hdl/mlr_out_reg.sv =====
// ----------------------------------------------------------------------------
// mlr_out_reg
// Output register of the result stream: holds one beat until taken, and
// takes a new one in the cycle the held beat leaves.
// ----------------------------------------------------------------------------
module mlr_out_reg #(
  parameter int DATA_BITS = 26
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic [DATA_BITS-1:0] push_data,
  output logic                 ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [DATA_BITS-1:0] out_data
);

  assign ready = !out_valid || out_ready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (push) begin
      out_data <= push_data;
    end
  end

endmodule

// ===== sim/midpoint_line_rasterizer_test.sv =====
// ----------------------------------------------------------------------------
// midpoint_line_rasterizer_test
// Self-checking testbench for the all-octant midpoint line rasterizer.
// ----------------------------------------------------------------------------
// Load and step beats go in from a queue through a bursty driver. Each
// accepted beat also runs through a line model kept in this file, which
// queues the pixel that the block should give. A monitor compares every
// output beat with the oldest queued pixel. Lines start with short directed
// cases (mirrored, swapped, reversed, tie on the decision, step with no
// line). Random lines follow, mostly short and fully stepped, some long ones
// cut off by a reload, with random stepping noise. The output side stalls
// on a pattern of its own and once holds off long enough to back up the
// input.
// ----------------------------------------------------------------------------
module midpoint_line_rasterizer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mlr_pkg::*;

  localparam int CB    = 12;
  localparam int IN_W  = ((4*CB+7)/8)*8;
  localparam int OUT_W = ((2*CB+7)/8)*8;
  localparam int LIMIT = 400000;
  localparam int TAIL  = 20;
  localparam int CMAX  = 2047;

  typedef struct {
    kind_t              kind;
    logic signed [CB-1:0] sx, sy, ex, ey;
  } beat_t;

  typedef struct {
    logic          valid;
    logic [CB-1:0] x, y;
    logic          last;
  } pixel_t;

  // ports
  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata = '0;
  logic             s_tuser = 1'b0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic             m_tuser;
  logic             m_tlast;

  // line model state
  logic                 line_on = 1'b0;
  logic                 flip_x = 1'b0;
  logic                 swap_axes = 1'b0;
  logic [CB-1:0]        maj_pos = '0;
  logic [CB-1:0]        min_pos = '0;
  logic [CB-1:0]        maj_stop = '0;
  logic signed [12:0]   maj_span = '0;
  logic signed [12:0]   min_span = '0;
  logic signed [15:0]   err_term = '0;

  beat_t  pending[$];
  pixel_t pixel_expect[$];

  logic in_fire = 1'b0;
  int   pushed = 0;
  int   beats_in = 0;
  int   lines_drawn = 0;
  int   pixels = 0;
  int   blanks = 0;
  int   errors = 0;
  int   cycles = 0;
  int   burst_left = 0;
  int   gap_left = 0;
  int   rx_cycle = 0;
  int   hold_left = 0;
  logic long_done = 1'b0;

  midpoint_line_rasterizer #(.COORD_BITS(CB)) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // start_x, start_y, end_x, end_y
    .s_tuser  (s_tuser),   // kind
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),   // pixel_x, pixel_y
    .m_tuser  (m_tuser),   // pixel_valid
    .m_tlast  (m_tlast)
  );

  // clock
  initial begin
    forever #6 clk = ~clk;
  end

  // line model: prepare on load, emit one pixel per step
  task automatic rasterize(input beat_t b);
    int ax, ay, bx, by, dx, dy, sa, sb, ma, mb, t;
    logic [CB-1:0] px, py, nxt;
    pixel_t p;
    if (b.kind == KIND_LOAD) begin
      ax = int'(b.sx);
      ay = int'(b.sy);
      bx = int'(b.ex);
      by = int'(b.ey);
      dx = bx - ax;
      dy = by - ay;
      // negative slope: mirror x so the line climbs
      flip_x = (dx < 0 && dy > 0) || (dx > 0 && dy < 0);
      if (flip_x) begin
        ax = -ax;
        bx = -bx;
      end
      // steep: y becomes the major axis
      swap_axes = (dy < 0 ? -dy : dy) > (dx < 0 ? -dx : dx);
      if (swap_axes) begin
        sa = ay; ma = ax; sb = by; mb = bx;
      end else begin
        sa = ax; ma = ay; sb = bx; mb = by;
      end
      if (sa > sb) begin
        t = sa; sa = sb; sb = t;
        t = ma; ma = mb; mb = t;
      end
      maj_span = 13'(sb - sa);
      min_span = 13'(mb - ma);
      maj_pos  = sa[CB-1:0];
      min_pos  = ma[CB-1:0];
      maj_stop = sb[CB-1:0];
      err_term = 16'(2*(mb - ma) - (sb - sa));
      line_on  = (sb != sa);
      if (line_on) lines_drawn++;
    end else if (!line_on) begin
      p = '{1'b0, {CB{1'b0}}, {CB{1'b0}}, 1'b0};
      pixel_expect = {pixel_expect, p};
      blanks++;
    end else begin
      px  = swap_axes ? min_pos : maj_pos;
      py  = swap_axes ? maj_pos : min_pos;
      nxt = maj_pos + 1'b1;
      if (flip_x) px = -px;
      p = '{1'b1, px, py, nxt == maj_stop};
      pixel_expect = {pixel_expect, p};
      // midpoint decision, a tie keeps the minor coordinate
      if (err_term > 0) begin
        min_pos  = min_pos + 1'b1;
        err_term = 16'(err_term + 2*(min_span - maj_span));
      end else begin
        err_term = 16'(err_term + 2*min_span);
      end
      maj_pos = nxt;
      if (p.last) line_on = 1'b0;
      pixels++;
    end
  endtask

  // stimulus helpers
  function automatic int rand_coord();
    int v;
    v = $urandom_range(2*CMAX);
    return v - CMAX;
  endfunction

  function automatic int near(input int c, input int reach);
    int v;
    v = $urandom_range(2*reach);
    v = c + v - reach;
    if (v > CMAX) v = CMAX;
    if (v < -CMAX) v = -CMAX;
    return v;
  endfunction

  task automatic push_load(input int sx, input int sy, input int ex, input int ey);
    beat_t b;
    b.kind = KIND_LOAD;
    b.sx = CB'(sx);
    b.sy = CB'(sy);
    b.ex = CB'(ex);
    b.ey = CB'(ey);
    pending = {pending, b};
    pushed++;
  endtask

  // step beats carry junk coordinates that the block must ignore
  task automatic push_steps(input int n);
    beat_t b;
    repeat (n) begin
      b.kind = KIND_STEP;
      b.sx = CB'($urandom);
      b.sy = CB'($urandom);
      b.ex = CB'($urandom);
      b.ey = CB'($urandom);
      pending = {pending, b};
      pushed++;
    end
  endtask

  // one random run: mostly a short line stepped to its end
  task automatic push_random_run();
    int r, sx, sy, ex, ey, adx, ady, span, n;
    r = $urandom_range(99);
    if (r < 6) begin
      push_steps($urandom_range(1, 3));
    end else if (r < 10) begin
      sx = rand_coord();
      sy = rand_coord();
      push_load(sx, sy, sx, sy);
      push_steps($urandom_range(1, 2));
    end else begin
      sx = rand_coord();
      sy = rand_coord();
      if (r < 14) begin
        ex = rand_coord();
        ey = rand_coord();
      end else begin
        ex = near(sx, r < 24 ? 64 : 10);
        ey = near(sy, r < 24 ? 64 : 10);
      end
      push_load(sx, sy, ex, ey);
      adx  = ex > sx ? ex - sx : sx - ex;
      ady  = ey > sy ? ey - sy : sy - ey;
      span = adx > ady ? adx : ady;
      if (span > 80) begin
        n = $urandom_range(1, 30);
      end else begin
        r = $urandom_range(9);
        if (r < 7)      n = span;
        else if (r < 9) n = span + $urandom_range(1, 2);
        else            n = $urandom_range(span);
      end
      push_steps(n);
    end
  endtask

  // wait until the queue has gone in and every pixel has come back
  task automatic wait_idle();
    while (pending.size() != 0 || s_tvalid) @(posedge clk);
    while (pixel_expect.size() != 0) @(posedge clk);
  endtask

  // driver: bursts of beats with random gaps
  always @(negedge clk) begin
    beat_t b;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_fire) begin
      if (gap_left > 0 || pending.size() == 0) begin
        if (gap_left > 0) gap_left--;
        s_tvalid <= 1'b0;
      end else begin
        b = pending.pop_front();
        s_tuser  <= b.kind;
        s_tdata  <= {b.ey, b.ex, b.sy, b.sx};
        s_tvalid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(40);
          gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
  end

  // receiver: rotating stall pattern plus one long hold-off
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      rx_cycle++;
      if (!long_done && beats_in >= 300) begin
        hold_left = 400;
        long_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        case ((rx_cycle / 97) % 4)
          0:       m_tready <= 1'b1;
          1:       m_tready <= 1'($urandom_range(1));
          2:       m_tready <= ($urandom_range(3) == 0);
          default: m_tready <= (rx_cycle % 3 != 0);
        endcase
      end
    end
  end

  // monitor: predict on input beats, check output beats
  always @(posedge clk) begin
    beat_t  b;
    pixel_t got, want;
    if (rst) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= s_tvalid && s_tready;
      if (s_tvalid && s_tready) begin
        b.kind = kind_t'(s_tuser);
        b.sx = s_tdata[CB-1:0];
        b.sy = s_tdata[2*CB-1:CB];
        b.ex = s_tdata[3*CB-1:2*CB];
        b.ey = s_tdata[4*CB-1:3*CB];
        rasterize(b);
        beats_in++;
      end
      if (m_tvalid && m_tready) begin
        got.valid = m_tuser;
        got.x     = m_tdata[CB-1:0];
        got.y     = m_tdata[2*CB-1:CB];
        got.last  = m_tlast;
        if (pixel_expect.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("tb: unexpected beat valid %0b x %0d y %0d last %0b",
                     got.valid, $signed(got.x), $signed(got.y), got.last);
        end else begin
          want = pixel_expect.pop_front();
          if (got.valid !== want.valid || got.x !== want.x ||
              got.y !== want.y || got.last !== want.last) begin
            errors++;
            if (errors <= 10)
              $display("tb: mismatch exp %0b %0d %0d %0b got %0b %0d %0d %0b",
                       want.valid, $signed(want.x), $signed(want.y), want.last,
                       got.valid, $signed(got.x), $signed(got.y), got.last);
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // main sequence
  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // step before any line, then a degenerate line
    push_steps(1);
    push_load(5, -5, 5, -5);
    push_steps(1);
    // shallow negative slope at the field corners, stepped past the end
    push_load(-2047, 2047, -2044, 2046);
    push_steps(4);
    // steep negative slope: mirrored and swapped
    push_load(2047, -2047, 2046, -2044);
    push_steps(3);
    // exact tie on the first decision, cut short by the next load
    push_load(0, 0, 4, 2);
    push_steps(2);
    // full-range diagonal, cut short
    push_load(-2047, -2047, 2047, 2047);
    push_steps(2);
    // reversed horizontal and reversed vertical
    push_load(3, 7, -1, 7);
    push_steps(4);
    push_load(0, 2047, 0, 2045);
    push_steps(2);

    while (pushed < 470) push_random_run();
    // sender holds until the block has drained
    wait_idle();
    while (pushed < 1050) push_random_run();
    wait_idle();
    repeat (TAIL) @(posedge clk);

    $display("run covered %0d beats in, %0d lines, %0d pixels and %0d blank steps",
             beats_in, lines_drawn, pixels, blanks);
    $display("all octants, mid-line reloads and output back-pressure in %0d cycles",
             cycles);
    if (errors == 0 && pixel_expect.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== midpoint_line_rasterizer.f =====
hdl/mlr_pkg.sv
hdl/mlr_setup.sv
hdl/mlr_stepper.sv
hdl/mlr_out_reg.sv
hdl/midpoint_line_rasterizer.sv
sim/midpoint_line_rasterizer_test.sv
